[rtl/core/twct_pkg.sv]
`default_nettype none
// ============================================================================
// twct_pkg: shared types and constants for the tile/world transform
// Word formats, opcode and register index codes, layout codes and the
// saturation helpers used by the datapath.
// ============================================================================

package twct_pkg;

    // Largest map side the nearest-center search walks.
    localparam int MAX_MAP_SIDE = 256;
    localparam int MAP_CNT_W    = $clog2(MAX_MAP_SIDE + 1);

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEX_SIDE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 3'd7;

    // Opcodes.
    localparam logic [1:0] OP_CORNER  = 2'd0;
    localparam logic [1:0] OP_DEPTH   = 2'd1;
    localparam logic [1:0] OP_TO_TILE = 2'd2;

    // Layout orientations.
    localparam logic [1:0] ORI_ORTHO   = 2'd0;
    localparam logic [1:0] ORI_ISO     = 2'd1;
    localparam logic [1:0] ORI_STAGGER = 2'd2;
    localparam logic [1:0] ORI_HEX     = 2'd3;

    // Divider geometry: numerator magnitude and divisor widths.
    localparam int DIV_W     = 48;
    localparam int NUM_W     = DIV_W + 1;
    localparam int DEN_W     = 26;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Wide datapath width for world positions and deltas.
    localparam int POS_W = 44;

    // Search deltas are clamped to this magnitude before squaring.
    localparam logic signed [POS_W-1:0] DELTA_LIM = 44'sd2147483647;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] tile_x;
        logic signed [15:0] tile_y;
        logic signed [39:0] world_x;
        logic signed [39:0] world_y;
    } cmd_t;

    typedef struct packed {
        logic signed [39:0] out_world_x;
        logic signed [39:0] out_world_y;
        logic signed [15:0] out_tile_x;
        logic signed [15:0] out_tile_y;
    } rsp_t;

    // Saturate a wide position to the 40-bit Q32.8 range.
    function automatic logic signed [39:0] sat40(input logic signed [POS_W-1:0] v);
        logic signed [39:0] r;
        if (v[POS_W-1:39] == {(POS_W-39){v[POS_W-1]}}) begin
            r = v[39:0];
        end
        else if (v[POS_W-1]) begin
            r = {1'b1, 39'd0};
        end
        else begin
            r = {1'b0, {39{1'b1}}};
        end
        return r;
    endfunction

    // Saturate a quotient to the 16-bit tile range.
    function automatic logic signed [15:0] sat16(input logic signed [NUM_W:0] v);
        logic signed [15:0] r;
        if (v[NUM_W:15] == {(NUM_W-14){v[NUM_W]}}) begin
            r = v[15:0];
        end
        else if (v[NUM_W]) begin
            r = {1'b1, 15'd0};
        end
        else begin
            r = {1'b0, {15{1'b1}}};
        end
        return r;
    endfunction

    // Clamp a search delta to the symmetric squaring range.
    function automatic logic signed [31:0] clamp_delta(input logic signed [POS_W-1:0] v);
        logic signed [31:0] r;
        if (v > DELTA_LIM) begin
            r = 32'(DELTA_LIM);
        end
        else if (v < -DELTA_LIM) begin
            r = 32'(-DELTA_LIM);
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Effective map side: zero means one, large values clip to the maximum.
    function automatic logic [MAP_CNT_W-1:0] map_side(input logic [8:0] v);
        logic [MAP_CNT_W-1:0] r;
        if (v == 9'd0) begin
            r = MAP_CNT_W'(1);
        end
        else if (32'(v) > 32'(MAX_MAP_SIDE)) begin
            r = MAP_CNT_W'(MAX_MAP_SIDE);
        end
        else begin
            r = MAP_CNT_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/tile_world_coordinate_transform.sv]
`default_nettype none
// ============================================================================
// tile_world_coordinate_transform: tile/world position mapping
// Gives a tile's world corner, its depth Y, or the tile under a world point
// for orthogonal, isometric, staggered and hexagonal layouts, using one
// shared 33x33 multiplier and a radix-2 divider under a small sequencer.
// ============================================================================
//
//   Channel  Dir  Handshake            Word
//   cmd      in   cmd_valid/cmd_stall  cmd_t: opcode, tile and world point
//   rsp      out  rsp_valid/rsp_stall  rsp_t: world corner, tile found
//   cfg      in   cfg_we               cfg_index, cfg_data
//
// From acceptance to the response: tile to world and depth words pass through
// the multiplier states; orthogonal and isometric world to tile run two 48-step
// divisions; staggered and hex world to tile visit every tile center of the map.
// The sequencer returns to idle before it accepts the next word.
// Reset idles the sequencer, clears the response valid and presets the layout registers.
// A finished word waits in the response register while the next word runs.

module tile_world_coordinate_transform (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  twct_pkg::cmd_t                     cmd_word,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output twct_pkg::rsp_t                     rsp_word,
    input  logic                               cfg_we,
    input  logic [twct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [twct_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import twct_pkg::*;

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_CMUL_X = 20'h00002,
        ST_CMUL_Y = 20'h00004,
        ST_CFIN   = 20'h00008,
        ST_LSUB   = 20'h00010,
        ST_IMUL1  = 20'h00020,
        ST_IMUL2  = 20'h00040,
        ST_IMUL3  = 20'h00080,
        ST_IMUL4  = 20'h00100,
        ST_IMUL5  = 20'h00200,
        ST_INUM   = 20'h00400,
        ST_DLOAD  = 20'h00800,
        ST_DRUN   = 20'h01000,
        ST_DFIN   = 20'h02000,
        ST_SINIT  = 20'h04000,
        ST_SDLT   = 20'h08000,
        ST_SSQX   = 20'h10000,
        ST_SSQY   = 20'h20000,
        ST_SCMP   = 20'h40000,
        ST_DONE   = 20'h80000
    } state_t;

    // Control and layout registers.
    state_t                   state_reg, state_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic [3:0]               mode_reg;
    logic [12:0]              tw_reg, th_reg, hs_reg;
    logic signed [39:0]       ox_reg, oy_reg;
    logic [8:0]               mw_cfg_reg, mh_cfg_reg;

    // Word and datapath registers.
    logic [1:0]               op_reg, op_next;
    logic signed [15:0]       tx_reg, tx_next, ty_reg, ty_next;
    logic signed [39:0]       wx_reg, wx_next, wy_reg, wy_next;
    logic signed [40:0]       lx_reg, lx_next, ly_reg, ly_next;
    logic signed [63:0]       prod_reg, prod_next;
    logic signed [55:0]       acc1_reg, acc1_next, acc2_reg, acc2_next;
    logic signed [NUM_W-1:0]  numx_reg, numx_next, numy_reg, numy_next;
    logic [DEN_W-1:0]         denx_reg, denx_next, deny_reg, deny_next;
    logic                     phase_reg, phase_next;
    logic [DIV_W-1:0]         div_q_reg, div_q_next;
    logic [DEN_W-1:0]         div_rem_reg, div_rem_next;
    logic [DEN_W-1:0]         div_den_reg, div_den_next;
    logic                     div_neg_reg, div_neg_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [MAP_CNT_W-1:0]     x_reg, x_next, y_reg, y_next;
    logic [MAP_CNT_W-1:0]     mw_reg, mw_next, mh_reg, mh_next;
    logic signed [POS_W-1:0]  cur_cx_reg, cur_cx_next, cur_cy_reg, cur_cy_next;
    logic signed [31:0]       dxc_reg, dxc_next, dyc_reg, dyc_next;
    logic [62:0]              dsum_reg, dsum_next;
    logic [63:0]              best_reg, best_next;
    logic                     have_reg, have_next;
    rsp_t                     res_reg, res_next;
    rsp_t                     rsp_word_reg, rsp_word_next;

    // Derived layout values.
    logic [12:0]              tw_eff, th_eff;
    logic [1:0]               orient;
    logic                     axis_y, even_idx, hex_on;
    logic [13:0]              pitch_w, pitch_h;
    logic [20:0]              step_x, step_y;
    logic signed [POS_W-1:0]  half_w_s, half_h_s, cx0, cy0;

    assign tw_eff   = (tw_reg == 13'd0) ? 13'd1 : tw_reg;
    assign th_eff   = (th_reg == 13'd0) ? 13'd1 : th_reg;
    assign orient   = mode_reg[1:0];
    assign axis_y   = mode_reg[2];
    assign even_idx = mode_reg[3];
    assign hex_on   = (orient == ORI_HEX) && (hs_reg != 13'd0);
    assign pitch_w  = hex_on ? (14'(tw_eff) + 14'(hs_reg)) : 14'(tw_eff);
    assign pitch_h  = hex_on ? (14'(th_eff) + 14'(hs_reg)) : 14'(th_eff);
    assign step_x   = axis_y ? {tw_eff, 8'd0} : {pitch_w, 7'd0};
    assign step_y   = axis_y ? {pitch_h, 7'd0} : {th_eff, 8'd0};
    assign half_w_s = $signed(POS_W'({tw_eff, 7'd0}));
    assign half_h_s = $signed(POS_W'({th_eff, 7'd0}));
    assign cx0      = POS_W'(ox_reg) + half_w_s;
    assign cy0      = POS_W'(oy_reg) + half_h_s;

    // Corner operands: world = origin + 128 * (a * b + offset).
    logic signed [16:0]       tx_ext, ty_ext, ca_x, ca_y;
    logic [14:0]              cb_x, cb_y;
    logic [15:0]              coff_x, coff_y;
    logic                     shift_c;

    assign tx_ext  = 17'(tx_reg);
    assign ty_ext  = 17'(ty_reg);
    assign shift_c = (axis_y ? ty_reg[0] : tx_reg[0]) ^ even_idx;

    always_comb
    begin
        ca_x   = tx_ext;
        ca_y   = ty_ext;
        cb_x   = 15'({tw_eff, 1'b0});
        cb_y   = 15'({th_eff, 1'b0});
        coff_x = 16'd0;
        coff_y = 16'd0;
        unique case (orient)
            ORI_ORTHO:
            begin
                ca_x = tx_ext;
            end
            ORI_ISO:
            begin
                ca_x = tx_ext - ty_ext;
                ca_y = tx_ext + ty_ext;
                cb_x = 15'(tw_eff);
                cb_y = 15'(th_eff);
            end
            default:
            begin
                if (axis_y)
                begin
                    cb_y = 15'(pitch_h);
                    if (shift_c)
                    begin
                        coff_x = 16'(tw_eff);
                    end
                end
                else
                begin
                    cb_x = 15'(pitch_w);
                    if (shift_c)
                    begin
                        coff_y = 16'(th_eff);
                    end
                end
            end
        endcase
        if (op_reg == OP_DEPTH)
        begin
            coff_y = coff_y + 16'({th_eff, 1'b0});
        end
    end

    // Shared multiplier: operands picked by the sequencer, product registered.
    logic signed [32:0]       mul_a, mul_b, tw_s, th_s;
    logic signed [65:0]       prod_full;

    assign tw_s = $signed({20'd0, tw_eff});
    assign th_s = $signed({20'd0, th_eff});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_CMUL_X:
            begin
                mul_a = 33'(ca_x);
                mul_b = $signed({18'd0, cb_x});
            end
            ST_CMUL_Y:
            begin
                mul_a = 33'(ca_y);
                mul_b = $signed({18'd0, cb_y});
            end
            ST_IMUL1:
            begin
                mul_a = $signed({1'b0, lx_reg[31:0]});
                mul_b = th_s;
            end
            ST_IMUL2:
            begin
                mul_a = 33'($signed(lx_reg[40:32]));
                mul_b = th_s;
            end
            ST_IMUL3:
            begin
                mul_a = $signed({1'b0, ly_reg[31:0]});
                mul_b = tw_s;
            end
            ST_IMUL4:
            begin
                mul_a = 33'($signed(ly_reg[40:32]));
                mul_b = tw_s;
            end
            ST_IMUL5:
            begin
                mul_a = tw_s;
                mul_b = th_s;
            end
            ST_SSQX:
            begin
                mul_a = 33'(dxc_reg);
                mul_b = 33'(dxc_reg);
            end
            ST_SSQY:
            begin
                mul_a = 33'(dyc_reg);
                mul_b = 33'(dyc_reg);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign prod_next = prod_full[63:0];

    // Divider step, load and sign correction.
    logic [DEN_W:0]           div_trial, div_diff;
    logic                     div_ge;
    logic signed [NUM_W-1:0]  div_load_n;
    logic signed [NUM_W:0]    div_qs, div_qs_inc, div_adj;

    assign div_trial  = {div_rem_reg, div_q_reg[DIV_W-1]};
    assign div_ge     = div_trial >= {1'b0, div_den_reg};
    assign div_diff   = div_trial - {1'b0, div_den_reg};
    assign div_load_n = phase_reg ? numy_reg : numx_reg;
    assign div_qs     = $signed({2'b00, div_q_reg});
    assign div_qs_inc = div_qs + $signed({{NUM_W{1'b0}}, (div_rem_reg != '0)});
    assign div_adj    = div_neg_reg ? -div_qs_inc : div_qs;

    // Search datapath: tile center deltas and the distance sum.
    logic                     s_shx, s_shy, s_last_x, s_last_y, s_better;
    logic signed [POS_W-1:0]  s_dx, s_dy;
    logic [63:0]              s_dist;
    logic signed [56:0]       iso_sum, iso_dif;

    assign s_shx    = axis_y && (y_reg[0] ^ even_idx);
    assign s_shy    = !axis_y && (x_reg[0] ^ even_idx);
    assign s_dx     = cur_cx_reg + (s_shx ? half_w_s : '0) - POS_W'(wx_reg);
    assign s_dy     = cur_cy_reg + (s_shy ? half_h_s : '0) - POS_W'(wy_reg);
    assign s_dist   = {1'b0, dsum_reg} + {1'b0, prod_reg[62:0]};
    assign s_better = !have_reg || (s_dist < best_reg);
    assign s_last_x = MAP_CNT_W'(x_reg + 1'b1) == mw_reg;
    assign s_last_y = MAP_CNT_W'(y_reg + 1'b1) == mh_reg;
    assign iso_sum  = 57'(acc2_reg) + 57'(acc1_reg);
    assign iso_dif  = 57'(acc2_reg) - 57'(acc1_reg);

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next    = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next = rsp_word_reg;
        op_next       = op_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        wx_next       = wx_reg;
        wy_next       = wy_reg;
        lx_next       = lx_reg;
        ly_next       = ly_reg;
        acc1_next     = acc1_reg;
        acc2_next     = acc2_reg;
        numx_next     = numx_reg;
        numy_next     = numy_reg;
        denx_next     = denx_reg;
        deny_next     = deny_reg;
        phase_next    = phase_reg;
        div_q_next    = div_q_reg;
        div_rem_next  = div_rem_reg;
        div_den_next  = div_den_reg;
        div_neg_next  = div_neg_reg;
        div_cnt_next  = div_cnt_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        mw_next       = mw_reg;
        mh_next       = mh_reg;
        cur_cx_next   = cur_cx_reg;
        cur_cy_next   = cur_cy_reg;
        dxc_next      = dxc_reg;
        dyc_next      = dyc_reg;
        dsum_next     = dsum_reg;
        best_next     = best_reg;
        have_next     = have_reg;
        res_next      = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next  = cmd_word.opcode;
                    tx_next  = cmd_word.tile_x;
                    ty_next  = cmd_word.tile_y;
                    wx_next  = cmd_word.world_x;
                    wy_next  = cmd_word.world_y;
                    res_next = '0;
                    priority if (cmd_word.opcode == OP_CORNER || cmd_word.opcode == OP_DEPTH)
                    begin
                        state_next = ST_CMUL_X;
                    end
                    else if (cmd_word.opcode == OP_TO_TILE)
                    begin
                        state_next = ST_LSUB;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CMUL_X:
            begin
                state_next = ST_CMUL_Y;
            end
            ST_CMUL_Y:
            begin
                // X product is ready; depth words leave world X at zero.
                if (op_reg == OP_CORNER)
                begin
                    res_next.out_world_x = sat40(POS_W'(ox_reg)
                        + ((POS_W'(prod_reg) + $signed(POS_W'(coff_x))) <<< 7));
                end
                state_next = ST_CFIN;
            end
            ST_CFIN:
            begin
                res_next.out_world_y = sat40(POS_W'(oy_reg)
                    + ((POS_W'(prod_reg) + $signed(POS_W'(coff_y))) <<< 7));
                state_next = ST_DONE;
            end
            ST_LSUB:
            begin
                lx_next = 41'(wx_reg) - 41'(ox_reg);
                ly_next = 41'(wy_reg) - 41'(oy_reg);
                priority if (orient == ORI_ORTHO)
                begin
                    state_next = ST_INUM;
                end
                else if (orient == ORI_ISO)
                begin
                    state_next = ST_IMUL1;
                end
                else
                begin
                    state_next = ST_SINIT;
                end
            end
            ST_IMUL1:
            begin
                state_next = ST_IMUL2;
            end
            ST_IMUL2:
            begin
                acc1_next  = 56'(prod_reg);
                state_next = ST_IMUL3;
            end
            ST_IMUL3:
            begin
                acc1_next  = acc1_reg + (56'(prod_reg) <<< 32);
                state_next = ST_IMUL4;
            end
            ST_IMUL4:
            begin
                acc2_next  = 56'(prod_reg);
                state_next = ST_IMUL5;
            end
            ST_IMUL5:
            begin
                acc2_next  = acc2_reg + (56'(prod_reg) <<< 32);
                state_next = ST_INUM;
            end
            ST_INUM:
            begin
                // Floor by 256 first; iso divides by tile area, ortho by width/height.
                if (orient == ORI_ISO)
                begin
                    numx_next = NUM_W'(iso_sum >>> 8);
                    numy_next = NUM_W'(iso_dif >>> 8);
                    denx_next = prod_reg[DEN_W-1:0];
                    deny_next = prod_reg[DEN_W-1:0];
                end
                else
                begin
                    numx_next = NUM_W'(lx_reg >>> 8);
                    numy_next = NUM_W'(ly_reg >>> 8);
                    denx_next = DEN_W'(tw_eff);
                    deny_next = DEN_W'(th_eff);
                end
                phase_next = 1'b0;
                state_next = ST_DLOAD;
            end
            ST_DLOAD:
            begin
                div_neg_next = div_load_n[NUM_W-1];
                div_q_next   = DIV_W'(div_load_n[NUM_W-1] ? -div_load_n : div_load_n);
                div_rem_next = '0;
                div_den_next = phase_reg ? deny_reg : denx_reg;
                div_cnt_next = '0;
                state_next   = ST_DRUN;
            end
            ST_DRUN:
            begin
                // One restoring step: the quotient bit shifts in at the bottom.
                div_rem_next = div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
                div_q_next   = {div_q_reg[DIV_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    state_next = ST_DFIN;
                end
            end
            ST_DFIN:
            begin
                if (phase_reg)
                begin
                    res_next.out_tile_y = sat16(div_adj);
                    state_next = ST_DONE;
                end
                else
                begin
                    res_next.out_tile_x = sat16(div_adj);
                    phase_next = 1'b1;
                    state_next = ST_DLOAD;
                end
            end
            ST_SINIT:
            begin
                x_next      = '0;
                y_next      = '0;
                mw_next     = map_side(mw_cfg_reg);
                mh_next     = map_side(mh_cfg_reg);
                cur_cx_next = cx0;
                cur_cy_next = cy0;
                have_next   = 1'b0;
                state_next  = ST_SDLT;
            end
            ST_SDLT:
            begin
                dxc_next   = clamp_delta(s_dx);
                dyc_next   = clamp_delta(s_dy);
                state_next = ST_SSQX;
            end
            ST_SSQX:
            begin
                state_next = ST_SSQY;
            end
            ST_SSQY:
            begin
                dsum_next  = prod_reg[62:0];
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                // First strict minimum wins, scanning row by row.
                if (s_better)
                begin
                    have_next = 1'b1;
                    best_next = s_dist;
                    res_next.out_tile_x = $signed(16'(x_reg));
                    res_next.out_tile_y = $signed(16'(y_reg));
                end
                state_next = ST_SDLT;
                if (!s_last_x)
                begin
                    x_next      = MAP_CNT_W'(x_reg + 1'b1);
                    cur_cx_next = cur_cx_reg + $signed(POS_W'(step_x));
                end
                else
                begin
                    x_next      = '0;
                    cur_cx_next = cx0;
                    y_next      = MAP_CNT_W'(y_reg + 1'b1);
                    cur_cy_next = cur_cy_reg + $signed(POS_W'(step_y));
                    if (s_last_y)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and layout configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            mode_reg      <= 4'd0;
            tw_reg        <= 13'd32;
            th_reg        <= 13'd32;
            hs_reg        <= 13'd0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            mw_cfg_reg    <= 9'd1;
            mh_cfg_reg    <= 9'd1;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LAYOUT_MODE: mode_reg   <= cfg_data[3:0];
                    CFG_TILE_WIDTH:  tw_reg     <= cfg_data[12:0];
                    CFG_TILE_HEIGHT: th_reg     <= cfg_data[12:0];
                    CFG_HEX_SIDE:    hs_reg     <= cfg_data[12:0];
                    CFG_ORIGIN_X:    ox_reg     <= $signed(cfg_data[39:0]);
                    CFG_ORIGIN_Y:    oy_reg     <= $signed(cfg_data[39:0]);
                    CFG_MAP_WIDTH:   mw_cfg_reg <= cfg_data[8:0];
                    CFG_MAP_HEIGHT:  mh_cfg_reg <= cfg_data[8:0];
                    default:         mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        wx_reg       <= wx_next;
        wy_reg       <= wy_next;
        lx_reg       <= lx_next;
        ly_reg       <= ly_next;
        prod_reg     <= prod_next;
        acc1_reg     <= acc1_next;
        acc2_reg     <= acc2_next;
        numx_reg     <= numx_next;
        numy_reg     <= numy_next;
        denx_reg     <= denx_next;
        deny_reg     <= deny_next;
        phase_reg    <= phase_next;
        div_q_reg    <= div_q_next;
        div_rem_reg  <= div_rem_next;
        div_den_reg  <= div_den_next;
        div_neg_reg  <= div_neg_next;
        div_cnt_reg  <= div_cnt_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        mw_reg       <= mw_next;
        mh_reg       <= mh_next;
        cur_cx_reg   <= cur_cx_next;
        cur_cy_reg   <= cur_cy_next;
        dxc_reg      <= dxc_next;
        dyc_reg      <= dyc_next;
        dsum_reg     <= dsum_next;
        best_reg     <= best_next;
        have_reg     <= have_next;
        res_reg      <= res_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

`ifndef SYNTHESIS
    // An accepted word always starts work on the next cycle.
    a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start work");

    // A new response word is only launched from the completion state.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside completion");

    // The search never scores a tile outside the map.
    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCMP) |-> ((x_reg < mw_reg) && (y_reg < mh_reg)))
        else $error("search index left the map");
`endif

endmodule

`default_nettype wire
